// File: design/tpf_pkg.sv
// Package for the transport stream PID filter with PAT rewrite.
// Holds shared constants, the result record type and register codes.
// No dependencies.
package tpf_pkg;

  localparam int PID_TABLE_ENTRIES = 8192;
  localparam int PID_W = 13;
  localparam int PUSH_MAX = 9;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW = 5;

  localparam logic [7:0] SYNC_BYTE = 8'h47;
  localparam logic [12:0] NULL_PID = 13'h1fff;
  localparam logic [31:0] CRC_POLY = 32'h04c11db7;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;
  localparam logic [8:0] MAX_PAT_OFF = 9'd171;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_SYNC = 2'd1,
    FAULT_PAT = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_PROGRAM = 2'd1,
    REG_PMT_PID = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] fault;
    logic eop;
    logic [7:0] data;
  } res_t;

endpackage

// File: design/tpf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tpf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 8192
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/tpf_res_fifo.sv
// Result queue that takes up to nine results per cycle and gives one per cycle.
// Depends on tpf_pkg.
module tpf_res_fifo (
  input  logic clk,
  input  logic rst,
  input  logic [3:0] push_n,
  input  tpf_pkg::res_t [8:0] push_data,
  input  logic pop,
  output tpf_pkg::res_t head,
  output logic not_empty,
  output logic room
);
  import tpf_pkg::*;

  res_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + FIFO_AW'(push_n);
      rptr <= rptr + FIFO_AW'(pop);
      count <= count + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < FIFO_DEPTH; j++) begin
      logic [FIFO_AW-1:0] off;
      off = FIFO_AW'(j) - wptr;
      if (off < FIFO_AW'(push_n)) begin
        mem[j] <= push_data[off[3:0]];
      end
    end
  end

  assign head = mem[rptr];
  assign not_empty = count != '0;
  assign room = count <= (FIFO_AW+1)'(FIFO_DEPTH - PUSH_MAX);

endmodule

// File: design/ts_pid_filter_pat_rewrite.sv
// Transport stream PID filter with PAT rewrite and continuity restamping.
// Throughput: one input item per cycle while the queue has room and no stale table
// read stalls; the fifth TS byte of a passed packet releases 5 or 9 results. The
// queue drains one result per cycle when m_tready is high; the PID table read is
// registered, and a mode change that moves the PID bytes stalls the fifth TS byte.
// Reset is synchronous; a pass over all 8192 entries then clears the PID table
// while the input is held off. Depends on tpf_pkg, tpf_ram and tpf_res_fifo.
module ts_pid_filter_pat_rewrite (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,   // [7:0] data_byte, [20:8] pid_value
  input  logic [0:0] s_tuser,    // [0] action
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic m_tlast,
  output logic [1:0] m_tuser,    // [1:0] fault_code
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import tpf_pkg::*;

  logic m2ts;
  logic [15:0] prog_num;
  logic [12:0] pmt_pid;

  logic s1_valid;
  logic s1_action;
  logic [7:0] s1_byte;
  logic [12:0] s1_pid;
  logic s1_go;

  logic clearing;
  logic [12:0] clr_addr;
  logic we;
  logic [12:0] waddr;
  logic [12:0] rd_addr;
  logic [12:0] rd_addr_q;
  logic rd_stale;
  logic rd_data;
  logic fwd;
  logic mark_we;

  logic [7:0] hold [9];
  logic [7:0] hold_next [9];
  logic [7:0] pos, pos_next;
  logic pass_f, pass_next;
  logic pat_f, pat_next;
  logic [7:0] off, off_next;
  logic [3:0] cc [2];
  logic [3:0] cc_next [2];
  logic [31:0] crc, crc_next;
  logic halted, halted_next;

  logic [3:0] push_n;
  res_t [8:0] push_data;
  res_t head;
  logic not_empty;
  logic room;
  logic pop;
  logic [3:0] pre;
  logic [7:0] last;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] v);
    logic [31:0] r;
    r = c ^ {v, 24'd0};
    for (int b = 0; b < 8; b++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] section_byte(input logic [3:0] k, input logic [15:0] pn,
                                              input logic [12:0] pp);
    logic [7:0] r;
    case (k)
      4'd1: r = 8'hb0;
      4'd2: r = 8'h0d;
      4'd4: r = 8'h01;
      4'd5: r = 8'hc1;
      4'd8: r = pn[15:8];
      4'd9: r = pn[7:0];
      4'd10: r = {3'b111, pp[12:8]};
      4'd11: r = pp[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2ts <= 1'b0;
      prog_num <= 16'd1;
      pmt_pid <= 13'd4096;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MODE: m2ts <= pwdata[0];
        REG_PROGRAM: prog_num <= pwdata[15:0];
        REG_PMT_PID: pmt_pid <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE: prdata = {31'd0, m2ts};
      REG_PROGRAM: prdata = {16'd0, prog_num};
      REG_PMT_PID: prdata = {19'd0, pmt_pid};
      default: prdata = 32'd0;
    endcase
  end

  assign rd_stale = !s1_action && (pos == {4'd0, pre} + 8'd4) &&
                    ({hold[pre + 4'd1][4:0], hold[pre + 4'd2]} != rd_addr_q);
  assign s1_go = s1_valid && room && !rd_stale;
  assign s_tready = !clearing && (!s1_valid || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_action <= s_tuser[0];
      s1_byte <= s_tdata[7:0];
      s1_pid <= s_tdata[20:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 13'd1;
      if (clr_addr == 13'(PID_TABLE_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mark_we = s1_go && s1_action && !halted;
  assign we = clearing || mark_we;
  assign waddr = clearing ? clr_addr : s1_pid;

  tpf_ram #(.WIDTH(1), .DEPTH(PID_TABLE_ENTRIES)) u_pid_table (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(!clearing),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= mark_we && (s1_pid == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
  end

  assign pre = m2ts ? 4'd4 : 4'd0;
  assign last = m2ts ? 8'd191 : 8'd187;

  always_comb begin
    logic adv;
    logic fault;
    logic [12:0] pid;
    logic [1:0] afc;
    logic [8:0] offw;
    logic [7:0] t;
    logic [7:0] k;
    logic [7:0] v;
    logic c;
    logic [3:0] i4;
    for (int i = 0; i < 9; i++) begin
      hold_next[i] = hold[i];
    end
    pos_next = pos;
    pass_next = pass_f;
    pat_next = pat_f;
    off_next = off;
    cc_next[0] = cc[0];
    cc_next[1] = cc[1];
    crc_next = crc;
    halted_next = halted;
    push_n = 4'd0;
    push_data = '0;
    adv = 1'b0;
    fault = 1'b0;
    pid = '0;
    afc = '0;
    offw = '0;
    t = '0;
    k = '0;
    v = s1_byte;
    c = 1'b0;
    i4 = '0;
    if (s1_go && !s1_action && !halted) begin
      if (pos < {4'd0, pre} + 8'd4) begin
        hold_next[pos[3:0]] = s1_byte;
        if (pos == {4'd0, pre} && s1_byte != SYNC_BYTE) begin
          halted_next = 1'b1;
          push_n = 4'd1;
          push_data[0].fault = FAULT_SYNC;
        end else begin
          adv = 1'b1;
        end
      end else if (pos == {4'd0, pre} + 8'd4) begin
        hold_next[pre + 4'd4] = s1_byte;
        pid = {hold[pre + 4'd1][4:0], hold[pre + 4'd2]};
        pass_next = (pid == NULL_PID) || (pid == '0) || (pid == pmt_pid) || rd_data || fwd;
        pat_next = 1'b0;
        if (pid == '0) begin
          afc = hold[pre + 4'd3][5:4];
          offw = (afc == 2'd3) ? 9'd5 + {1'b0, s1_byte} : 9'd4;
          if (!hold[pre + 4'd1][6] || afc == 2'd0 || afc == 2'd2 || offw > MAX_PAT_OFF) begin
            fault = 1'b1;
            halted_next = 1'b1;
            pass_next = 1'b0;
            push_n = 4'd1;
            push_data[0].fault = FAULT_PAT;
          end else begin
            off_next = offw[7:0];
            crc_next = CRC_INIT;
            pat_next = 1'b1;
          end
        end
        if (!fault) begin
          if (pid == '0 || pid == pmt_pid) begin
            c = (pid != '0);
            hold_next[pre + 4'd3] = {hold[pre + 4'd3][7:4], cc[c]};
            cc_next[c] = cc[c] + 4'd1;
          end
          if (pass_next) begin
            for (int i = 0; i < 9; i++) begin
              i4 = 4'(i);
              if (i4 <= pre + 4'd4) begin
                push_data[i].data = hold_next[i];
              end
            end
            if (pat_next && off_next == 8'd4) begin
              push_data[pre + 4'd4].data = 8'h00;
            end
            push_n = pre + 4'd5;
          end
          adv = 1'b1;
        end
      end else begin
        if (pass_f) begin
          if (pat_f) begin
            t = pos - {4'd0, pre};
            k = t - off - 8'd1;
            if (t < off) begin
              v = s1_byte;
            end else if (t == off) begin
              v = 8'h00;
            end else if (k < 8'd12) begin
              v = section_byte(k[3:0], prog_num, pmt_pid);
              crc_next = crc_byte(crc, v);
            end else if (k < 8'd16) begin
              case (k[1:0])
                2'd0: v = crc[31:24];
                2'd1: v = crc[23:16];
                2'd2: v = crc[15:8];
                default: v = crc[7:0];
              endcase
            end else begin
              v = 8'hff;
            end
          end
          push_n = 4'd1;
          push_data[0].data = v;
          push_data[0].eop = (pos >= last);
        end
        adv = 1'b1;
      end
      if (adv) begin
        if (pos >= last) begin
          pos_next = '0;
          pass_next = 1'b0;
          pat_next = 1'b0;
        end else begin
          pos_next = pos + 8'd1;
        end
      end
    end
  end

  assign rd_addr = {hold_next[pre + 4'd1][4:0], hold_next[pre + 4'd2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      pass_f <= 1'b0;
      pat_f <= 1'b0;
      off <= '0;
      cc[0] <= '0;
      cc[1] <= '0;
      crc <= CRC_INIT;
      halted <= 1'b0;
    end else begin
      pos <= pos_next;
      pass_f <= pass_next;
      pat_f <= pat_next;
      off <= off_next;
      cc[0] <= cc_next[0];
      cc[1] <= cc_next[1];
      crc <= crc_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      hold[i] <= hold_next[i];
    end
  end

  assign pop = m_tvalid && m_tready;

  tpf_res_fifo u_res_fifo (
    .clk(clk),
    .rst(rst),
    .push_n(push_n),
    .push_data(push_data),
    .pop(pop),
    .head(head),
    .not_empty(not_empty),
    .room(room)
  );

  assign m_tvalid = not_empty;
  assign m_tdata = head.data;
  assign m_tlast = head.eop;
  assign m_tuser = head.fault;

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt state was left without reset");
  a_no_push_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> push_n == 4'd0)
    else $error("result produced while halted");
  a_push_needs_go: assert property (@(posedge clk) disable iff (rst)
    push_n != 4'd0 |-> s1_go)
    else $error("result produced without a processed transaction");
  a_fwd_after_mark: assert property (@(posedge clk) disable iff (rst)
    fwd |-> $past(mark_we))
    else $error("table forward without a preceding mark");
  a_clear_writes: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (we && !mark_we))
    else $error("table clear pass interrupted");
`endif

endmodule

// File: tb/tb_ts_pid_filter_pat_rewrite.sv
// Testbench for ts_pid_filter_pat_rewrite: stream bytes and PID marks in, filtered and
// rewritten packets out, each result checked against a predictor built into this file.
// Depends on tpf_pkg and the block under test.
module tb_ts_pid_filter_pat_rewrite;
  import tpf_pkg::*;

  localparam int LIMIT = 600000;
  localparam int SETTLE = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tlast;
  logic [1:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ts_pid_filter_pat_rewrite u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Filter model state.
  bit cfg_mode;
  logic [15:0] cfg_prog;
  logic [12:0] cfg_pmt;
  bit sel_tbl [PID_TABLE_ENTRIES];
  logic [7:0] pos_q;
  logic [7:0] hold [9];
  bit f_pass, f_pat, halted;
  logic [7:0] pat_off;
  logic [3:0] ccnt [2];
  logic [31:0] crc;

  res_t pending_bytes[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  function automatic void push_res(logic [7:0] d, logic e, fault_t f);
    res_t r;
    r.data = d;
    r.eop = e;
    r.fault = f;
    pending_bytes = {pending_bytes, r};
  endfunction

  function automatic logic [7:0] pat_out(int t, logic [7:0] orig);
    int k;
    logic [7:0] v;
    if (t < pat_off) return orig;
    if (t == pat_off) return 8'h00;
    k = t - pat_off - 1;
    if (k < 12) begin
      case (k)
        1: v = 8'hb0;
        2: v = 8'h0d;
        4: v = 8'h01;
        5: v = 8'hc1;
        8: v = cfg_prog[15:8];
        9: v = cfg_prog[7:0];
        10: v = {3'b111, cfg_pmt[12:8]};
        11: v = cfg_pmt[7:0];
        default: v = 8'h00;
      endcase
      crc = crc ^ {v, 24'h0};
      for (int i = 0; i < 8; i++) crc = crc[31] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      return v;
    end
    if (k < 16) return 8'(crc >> (8 * (15 - k)));
    return 8'hff;
  endfunction

  function automatic void predict(bit act, logic [7:0] b, logic [12:0] pv);
    int pre, last, pos, pid, afc, off, c;
    logic [7:0] v;
    if (halted) return;
    if (act) begin
      sel_tbl[pv] = 1'b1;
      return;
    end
    pre = cfg_mode ? 4 : 0;
    last = cfg_mode ? 191 : 187;
    pos = pos_q;
    if (pos < pre + 4) begin
      hold[pos] = b;
      if (pos == pre && b != SYNC_BYTE) begin
        halted = 1'b1;
        push_res(8'h00, 1'b0, FAULT_SYNC);
        return;
      end
    end else if (pos == pre + 4) begin
      hold[pos] = b;
      pid = {hold[pre+1][4:0], hold[pre+2]};
      f_pass = pid == NULL_PID || pid == 0 || pid == cfg_pmt || sel_tbl[pid];
      f_pat = 1'b0;
      if (pid == 0) begin
        afc = hold[pre+3][5:4];
        off = afc == 3 ? 5 + hold[pre+4] : 4;
        if (!hold[pre+1][6] || afc == 0 || afc == 2 || off + 17 > 188) begin
          halted = 1'b1;
          f_pass = 1'b0;
          push_res(8'h00, 1'b0, FAULT_PAT);
          return;
        end
        pat_off = 8'(off);
        crc = CRC_INIT;
        f_pat = 1'b1;
      end
      if (pid == 0 || pid == cfg_pmt) begin
        c = pid == 0 ? 0 : 1;
        hold[pre+3][3:0] = ccnt[c];
        ccnt[c] = ccnt[c] + 4'd1;
      end
      if (f_pass) begin
        for (int i = 0; i <= pre + 4; i++) begin
          v = hold[i];
          if (i == pre + 4 && f_pat) v = pat_out(4, v);
          push_res(v, 1'b0, FAULT_NONE);
        end
      end
    end else if (f_pass) begin
      v = b;
      if (f_pat) v = pat_out(pos - pre, b);
      push_res(v, pos >= last, FAULT_NONE);
    end
    if (pos >= last) begin
      pos_q = '0;
      f_pass = 1'b0;
      f_pat = 1'b0;
    end else begin
      pos_q = 8'(pos + 1);
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: byte %h last %b fault %0d",
                                   m_tdata, m_tlast, m_tuser);
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata !== want.data || m_tlast !== want.eop || m_tuser !== want.fault) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte %h last %b fault %0d, got %h %b %0d",
                     want.data, want.eop, want.fault, m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  task automatic send_item(bit act, logic [7:0] b, logic [12:0] pv);
    while (!calm && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {3'b000, pv, b};
    do @(posedge clk); while (!s_tready);
    predict(act, b, pv);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_MODE: cfg_mode = val[0];
      REG_PROGRAM: cfg_prog = val[15:0];
      REG_PMT_PID: cfg_pmt = val[12:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A nonzero cut sends only the first cut bytes of the packet.
  task automatic send_packet(logic [12:0] pid, bit pusi, logic [1:0] afc, logic [7:0] alen,
                             int cut);
    int n;
    int t;
    logic [7:0] b;
    n = cfg_mode ? 192 : 188;
    if (cut != 0) n = cut;
    for (int i = 0; i < n; i++) begin
      calm = cut == 0 && i >= 48 && i < 144;
      t = i - (cfg_mode ? 4 : 0);
      case (t)
        0: b = SYNC_BYTE;
        1: b = {1'($urandom), pusi, 1'($urandom), pid[12:8]};
        2: b = pid[7:0];
        3: b = {2'($urandom), afc, 4'($urandom)};
        4: b = afc == 2'd3 ? alen : 8'($urandom);
        default: b = 8'($urandom);
      endcase
      send_item(1'b0, b, 13'($urandom));
    end
    calm = 1'b0;
  endtask

  task automatic good_pat();
    if ($urandom_range(1)) send_packet(13'd0, 1'b1, 2'd1, 8'($urandom), 0);
    else send_packet(13'd0, 1'b1, 2'd3, 8'($urandom_range(166)), 0);
  endtask

  task automatic test_marks();
    send_item(1'b1, 8'hff, 13'd0);
    send_item(1'b1, 8'h00, 13'h1fff);
    send_item(1'b1, 8'h5a, 13'h0aaa);
    send_item(1'b1, 8'ha5, 13'h1555);
    send_item(1'b1, 8'h00, 13'h0100);
  endtask

  task automatic test_pat();
    drain();
    write_reg(REG_MODE, 32'($urandom_range(1)));
    write_reg(REG_PROGRAM, 32'($urandom_range(65535, 1)));
    write_reg(REG_PMT_PID, 32'($urandom_range(8191)));
    good_pat();
  endtask

  task automatic test_fault();
    drain();
    case ($urandom_range(4))
      0: begin
        repeat (cfg_mode ? 4 : 0) send_item(1'b0, 8'($urandom), 13'($urandom));
        send_item(1'b0, 8'h46, 13'($urandom));
      end
      1: send_packet(13'd0, 1'b0, 2'd1, 8'd0, 12);
      2: send_packet(13'd0, 1'b1, 2'd0, 8'd0, 12);
      3: send_packet(13'd0, 1'b1, 2'd2, 8'd0, 12);
      default: send_packet(13'd0, 1'b1, 2'd3, 8'd167, 12);
    endcase
    send_item(1'b1, 8'h00, 13'h0123);
    send_item(1'b0, SYNC_BYTE, 13'd0);
  endtask

  initial begin
    cfg_mode = 1'b0;
    cfg_prog = 16'd1;
    cfg_pmt = 13'd4096;
    pos_q = '0;
    f_pass = 1'b0;
    f_pat = 1'b0;
    halted = 1'b0;
    pat_off = '0;
    ccnt[0] = '0;
    ccnt[1] = '0;
    crc = CRC_INIT;
    foreach (hold[i]) hold[i] = '0;
    foreach (sel_tbl[i]) sel_tbl[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_marks();
    test_pat();
    test_fault();
    drain();
    if (pending_bytes.size() != 0) errors++;
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/tpf_pkg.sv
design/tpf_ram.sv
design/tpf_res_fifo.sv
design/ts_pid_filter_pat_rewrite.sv
tb/tb_ts_pid_filter_pat_rewrite.sv
